/* hw/rtl/wsm_pkg.sv */
// Shared constants and types for the wavelet spectrum multiply block.
`default_nettype none

package wsm_pkg;

  localparam int unsigned TABLE_SIZE = 4096;
  localparam int unsigned ADDR_W     = $clog2(TABLE_SIZE);
  localparam int unsigned POS_W      = 12;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned STEP_W     = 24;
  localparam int unsigned END_W      = 12;
  localparam int unsigned FRAC_TABLE = 14;
  localparam int unsigned FRAC_STEP  = 12;
  localparam int unsigned IDX_FULL_W = STEP_W + POS_W - FRAC_STEP;
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W + 1;
  localparam int unsigned SHIFT_W    = PROD_W - FRAC_TABLE;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = STEP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONJ_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SIDED = 2'd3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET    = 24'd4096;
  localparam logic [END_W-1:0]  END_BIN_RESET = 12'd2048;

  typedef struct packed {
    logic mul_en;
    logic out_en;
    logic neg;
    logic zero;
  } wsm_lane_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/wsm_coef_table.sv */
// Mother-wavelet spectrum table with one write port and a registered read port.
`default_nettype none

module wsm_coef_table import wsm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [COEF_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [COEF_W-1:0] rdata_o
);

  logic [COEF_W-1:0] mem [TABLE_SIZE];
  logic [COEF_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/wsm_scale_lane.sv */
// One product lane: multiply stage, then negate, floor shift and saturate.
`default_nettype none

module wsm_scale_lane import wsm_pkg::*; (
  input  wire logic                       clk_i,
  input  wire wsm_lane_ctrl_t             ctrl_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic        [COEF_W-1:0]   coef_i,
  output logic signed      [SAMPLE_W-1:0] result_o
);

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic                       neg_q, zero_q;
  logic signed [PROD_W-1:0]   adj;
  logic signed [SHIFT_W-1:0]  shifted;
  logic [SHIFT_W-SAMPLE_W:0]  top_bits;
  logic signed [SAMPLE_W-1:0] result_d, result_q;

  assign prod_d = $signed(sample_i) * $signed({1'b0, coef_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
      neg_q  <= ctrl_i.neg;
      zero_q <= ctrl_i.zero;
    end
  end

  always_comb begin
    adj      = neg_q ? -prod_q : prod_q;
    shifted  = adj[PROD_W-1:FRAC_TABLE];
    top_bits = shifted[SHIFT_W-1:SAMPLE_W-1];
    if (zero_q) begin
      result_d = '0;
    end else if ((top_bits == '0) || (top_bits == '1)) begin
      result_d = shifted[SAMPLE_W-1:0];
    end else if (shifted[SHIFT_W-1]) begin
      result_d = SAT_MIN;
    end else begin
      result_d = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_en) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

/* hw/rtl/wavelet_spectrum_multiply_core.sv */
// Top level of the wavelet spectrum multiply block: handshake, index stage and lanes.
//
// Input items arrive on in_valid_i / in_stall_o; a transfer happens on a rising
// edge with in_valid_i high and in_stall_o low. A load item (operation 0) writes
// table_value_i at position_i into the mother table and gives no result. A
// process item (operation 1) gives one result on out_valid_o / out_stall_i.
// The pipeline has four register stages: table index from step times bin,
// table read, four 32x17 multiplies, then negation, floor shift and saturation.
// A result is offered once its item has passed all four register stages. One
// item can be taken every cycle while in_stall_o is low. Each stage advances on its
// own, so while the receiver stalls the empty stages still fill; in_stall_o
// rises only once all four stages hold an item. Items are never dropped or
// repeated. Reset empties the pipeline and sets the registers to their defaults;
// the table contents are undefined until loaded. Configuration is written through
// cfg_we_i, cfg_index_i and cfg_data_i and must only change while the block is idle.
`default_nettype none

module wavelet_spectrum_multiply_core import wsm_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       operation_i,
  input  wire logic        [POS_W-1:0]    position_i,
  input  wire logic        [COEF_W-1:0]   table_value_i,
  input  wire logic signed [SAMPLE_W-1:0] bin_re_i,
  input  wire logic signed [SAMPLE_W-1:0] bin_im_i,
  input  wire logic signed [SAMPLE_W-1:0] mirror_re_i,
  input  wire logic signed [SAMPLE_W-1:0] mirror_im_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic             [POS_W-1:0]    bin_index_o,
  output logic signed      [SAMPLE_W-1:0] out_re_o,
  output logic signed      [SAMPLE_W-1:0] out_im_o,
  output logic signed      [SAMPLE_W-1:0] mirror_out_re_o,
  output logic signed      [SAMPLE_W-1:0] mirror_out_im_o,
  output logic                            in_band_o
);

  logic [STEP_W-1:0] step_q;
  logic [END_W-1:0]  end_bin_q;
  logic              conj_mode_q;
  logic              double_sided_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic ready1, ready2, ready3, ready4;
  logic go1;

  logic [STEP_W+POS_W-1:0] idx_prod;
  logic [IDX_FULL_W-1:0]   idx_full;
  logic [ADDR_W-1:0]       idx_d;

  logic                       op1_q, inb1_q;
  logic [POS_W-1:0]           pos1_q;
  logic [COEF_W-1:0]          tv1_q;
  logic [ADDR_W-1:0]          idx1_q;
  logic signed [SAMPLE_W-1:0] bre1_q, bim1_q, mre1_q, mim1_q;

  logic                       inb2_q;
  logic [POS_W-1:0]           pos2_q;
  logic signed [SAMPLE_W-1:0] bre2_q, bim2_q, mre2_q, mim2_q;
  logic [COEF_W-1:0]          coef2;

  logic             inb3_q, inb4_q;
  logic [POS_W-1:0] pos3_q, pos4_q;

  wsm_lane_ctrl_t ctrl_plain, ctrl_neg, ctrl_mplain, ctrl_mneg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= STEP_RESET;
      end_bin_q      <= END_BIN_RESET;
      conj_mode_q    <= 1'b0;
      double_sided_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STEP:         step_q         <= cfg_data_i[STEP_W-1:0];
        CFG_END_BIN:      end_bin_q      <= cfg_data_i[END_W-1:0];
        CFG_CONJ_MODE:    conj_mode_q    <= cfg_data_i[0];
        CFG_DOUBLE_SIDED: double_sided_q <= cfg_data_i[0];
        default:          step_q         <= step_q;
      endcase
    end
  end

  assign ready4     = !v4_q || !out_stall_i;
  assign ready3     = !v3_q || ready4;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign go1        = v1_q && ready2;
  assign in_stall_o = !ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q && (op1_q == OP_PROCESS);
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (ready4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_comb begin
    idx_prod = step_q * position_i;
    idx_full = idx_prod[STEP_W+POS_W-1:FRAC_STEP];
    if (idx_full > IDX_FULL_W'(TABLE_SIZE - 1)) begin
      idx_d = ADDR_W'(TABLE_SIZE - 1);
    end else begin
      idx_d = idx_full[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      op1_q  <= operation_i;
      pos1_q <= position_i;
      tv1_q  <= table_value_i;
      idx1_q <= idx_d;
      inb1_q <= position_i < end_bin_q;
      bre1_q <= bin_re_i;
      bim1_q <= bin_im_i;
      mre1_q <= mirror_re_i;
      mim1_q <= mirror_im_i;
    end
    if (ready2) begin
      inb2_q <= inb1_q;
      pos2_q <= pos1_q;
      bre2_q <= bre1_q;
      bim2_q <= bim1_q;
      mre2_q <= mre1_q;
      mim2_q <= mim1_q;
    end
    if (ready3) begin
      inb3_q <= inb2_q;
      pos3_q <= pos2_q;
    end
    if (ready4) begin
      inb4_q <= inb3_q;
      pos4_q <= pos3_q;
    end
  end

  wsm_coef_table u_table (
    .clk_i   (clk_i),
    .we_i    (go1 && (op1_q == OP_LOAD)),
    .waddr_i (pos1_q[ADDR_W-1:0]),
    .wdata_i (tv1_q),
    .re_i    (ready2),
    .raddr_i (idx1_q),
    .rdata_o (coef2)
  );

  always_comb begin
    ctrl_plain.mul_en  = ready3;
    ctrl_plain.out_en  = ready4;
    ctrl_plain.neg     = 1'b0;
    ctrl_plain.zero    = !inb2_q;
    ctrl_neg           = ctrl_plain;
    ctrl_neg.neg       = conj_mode_q;
    ctrl_mplain        = ctrl_plain;
    ctrl_mplain.zero   = !inb2_q || !double_sided_q;
    ctrl_mneg          = ctrl_mplain;
    ctrl_mneg.neg      = conj_mode_q;
  end

  wsm_scale_lane u_lane_re (
    .clk_i(clk_i), .ctrl_i(ctrl_plain), .sample_i(bre2_q), .coef_i(coef2),
    .result_o(out_re_o)
  );

  wsm_scale_lane u_lane_im (
    .clk_i(clk_i), .ctrl_i(ctrl_neg), .sample_i(bim2_q), .coef_i(coef2),
    .result_o(out_im_o)
  );

  wsm_scale_lane u_lane_mre (
    .clk_i(clk_i), .ctrl_i(ctrl_mneg), .sample_i(mre2_q), .coef_i(coef2),
    .result_o(mirror_out_re_o)
  );

  wsm_scale_lane u_lane_mim (
    .clk_i(clk_i), .ctrl_i(ctrl_mplain), .sample_i(mim2_q), .coef_i(coef2),
    .result_o(mirror_out_im_o)
  );

  assign out_valid_o = v4_q;
  assign bin_index_o = pos4_q;
  assign in_band_o   = inb4_q;

`ifndef SYNTH
  a_out_of_band_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_band_o) |-> (out_re_o == '0 && out_im_o == '0 &&
      mirror_out_re_o == '0 && mirror_out_im_o == '0))
    else $error("Out-of-band result carries non-zero products.");

  a_single_sided_mirror_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !double_sided_q) |-> (mirror_out_re_o == '0 && mirror_out_im_o == '0))
    else $error("Single-sided result carries non-zero mirror products.");

  a_load_gives_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go1 && (op1_q == OP_LOAD)) |=> !v2_q)
    else $error("A table load entered the product stages.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("Input stalled while a pipeline stage was empty.");
`endif

endmodule

`default_nettype wire

/* dv/wsm_checker.sv */
// Checker for the wavelet spectrum multiply block: predicts every result and compares each transfer.
module wsm_checker
  import wsm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       operation_i,
  input  logic [POS_W-1:0]           position_i,
  input  logic [COEF_W-1:0]          table_value_i,
  input  logic signed [SAMPLE_W-1:0] bin_re_i,
  input  logic signed [SAMPLE_W-1:0] bin_im_i,
  input  logic signed [SAMPLE_W-1:0] mirror_re_i,
  input  logic signed [SAMPLE_W-1:0] mirror_im_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [POS_W-1:0]           bin_index_i,
  input  logic [SAMPLE_W-1:0]        out_re_i,
  input  logic [SAMPLE_W-1:0]        out_im_i,
  input  logic [SAMPLE_W-1:0]        mirror_out_re_i,
  input  logic [SAMPLE_W-1:0]        mirror_out_im_i,
  input  logic                       in_band_i,
  output int unsigned                mismatches_o,
  output int unsigned                pending_o,
  output int unsigned                results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0]    bin;
    logic [SAMPLE_W-1:0] re;
    logic [SAMPLE_W-1:0] im;
    logic [SAMPLE_W-1:0] mirror_re;
    logic [SAMPLE_W-1:0] mirror_im;
    logic                in_band;
  } bin_result_t;

  logic [COEF_W-1:0]       coef_table [TABLE_SIZE];
  logic [STEP_W-1:0]       step_q;
  logic [END_W-1:0]        end_bin_q;
  logic                    conj_q;
  logic                    double_q;
  bin_result_t             pending_products [$];
  bin_result_t             want;
  logic [STEP_W+POS_W-1:0] scaled_pos;
  logic [COEF_W-1:0]       coef;

  // Product with a UQ2.14 coefficient, floored after the shift and saturated.
  function automatic logic [SAMPLE_W-1:0] daughter_product(
    input logic signed [SAMPLE_W-1:0] sample,
    input logic [COEF_W-1:0]          c,
    input logic                       negate
  );
    longint p;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    lo = -hi - 1;
    p = longint'(sample) * longint'(c);
    if (negate) begin
      p = -p;
    end
    p = p >>> FRAC_TABLE;
    if (p > hi) begin
      p = hi;
    end
    if (p < lo) begin
      p = lo;
    end
    return p[SAMPLE_W-1:0];
  endfunction

  task automatic compare_field(input string name, input logic [SAMPLE_W-1:0] want_v,
                               input logic [SAMPLE_W-1:0] got_v);
    if (got_v !== want_v) begin
      if (mismatches_o < 10) begin
        $display("Mismatch in %s for bin %0d: expected %h, got %h",
                 name, want.bin, want_v, got_v);
      end
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    = STEP_RESET;
      end_bin_q = END_BIN_RESET;
      conj_q    = 1'b0;
      double_q  = 1'b0;
      pending_products.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_STEP:         step_q    = cfg_data_i[STEP_W-1:0];
          CFG_END_BIN:      end_bin_q = cfg_data_i[END_W-1:0];
          CFG_CONJ_MODE:    conj_q    = cfg_data_i[0];
          CFG_DOUBLE_SIDED: double_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (pending_products.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("Result transfer for bin %0d arrived with nothing expected", bin_index_i);
          end
          mismatches_o++;
        end else begin
          want = pending_products.pop_front();
          compare_field("bin_index", SAMPLE_W'(want.bin), SAMPLE_W'(bin_index_i));
          compare_field("out_re", want.re, out_re_i);
          compare_field("out_im", want.im, out_im_i);
          compare_field("mirror_out_re", want.mirror_re, mirror_out_re_i);
          compare_field("mirror_out_im", want.mirror_im, mirror_out_im_i);
          compare_field("in_band", SAMPLE_W'(want.in_band), SAMPLE_W'(in_band_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_LOAD) begin
          coef_table[position_i] = table_value_i;
        end else begin
          want     = '0;
          want.bin = position_i;
          if (position_i < end_bin_q) begin
            scaled_pos = step_q * position_i;
            scaled_pos = scaled_pos >> FRAC_STEP;
            if (scaled_pos > TABLE_SIZE - 1) begin
              scaled_pos = (STEP_W+POS_W)'(TABLE_SIZE - 1);
            end
            coef         = coef_table[scaled_pos[ADDR_W-1:0]];
            want.in_band = 1'b1;
            want.re      = daughter_product(bin_re_i, coef, 1'b0);
            want.im      = daughter_product(bin_im_i, coef, conj_q);
            if (double_q) begin
              want.mirror_re = daughter_product(mirror_re_i, coef, conj_q);
              want.mirror_im = daughter_product(mirror_im_i, coef, 1'b0);
            end
          end
          pending_products.push_back(want);
        end
      end
      pending_o = pending_products.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the wavelet spectrum multiply block: stimulus, handshake pacing and verdict.
module tb_top import wsm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_STEP;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       operation = OP_LOAD;
  logic [POS_W-1:0]           position = '0;
  logic [COEF_W-1:0]          table_value = '0;
  logic signed [SAMPLE_W-1:0] bin_re = '0;
  logic signed [SAMPLE_W-1:0] bin_im = '0;
  logic signed [SAMPLE_W-1:0] mirror_re = '0;
  logic signed [SAMPLE_W-1:0] mirror_im = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [POS_W-1:0]           bin_index;
  logic signed [SAMPLE_W-1:0] out_re;
  logic signed [SAMPLE_W-1:0] out_im;
  logic signed [SAMPLE_W-1:0] mirror_out_re;
  logic signed [SAMPLE_W-1:0] mirror_out_im;
  logic                       in_band;

  int unsigned       mismatches;
  int unsigned       pending;
  int unsigned       results;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  int unsigned       load_count = 0;
  int unsigned       bin_count = 0;
  int unsigned       setting_count = 1;
  logic [STEP_W-1:0] cur_step = STEP_RESET;
  logic [END_W-1:0]  cur_end = END_BIN_RESET;
  bit                loaded [TABLE_SIZE];

  always #5 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

  wavelet_spectrum_multiply_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .position_i      (position),
    .table_value_i   (table_value),
    .bin_re_i        (bin_re),
    .bin_im_i        (bin_im),
    .mirror_re_i     (mirror_re),
    .mirror_im_i     (mirror_im),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .bin_index_o     (bin_index),
    .out_re_o        (out_re),
    .out_im_o        (out_im),
    .mirror_out_re_o (mirror_out_re),
    .mirror_out_im_o (mirror_out_im),
    .in_band_o       (in_band)
  );

  wsm_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .position_i      (position),
    .table_value_i   (table_value),
    .bin_re_i        (bin_re),
    .bin_im_i        (bin_im),
    .mirror_re_i     (mirror_re),
    .mirror_im_i     (mirror_im),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .bin_index_i     (bin_index),
    .out_re_i        (out_re),
    .out_im_i        (out_im),
    .mirror_out_re_i (mirror_out_re),
    .mirror_out_im_i (mirror_out_im),
    .in_band_i       (in_band),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .results_o       (results)
  );

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 16'h4000;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4:       return $urandom_range(0, 255);
      5:       return -$urandom_range(1, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_bin();
    int b;
    case ($urandom_range(0, 9))
      0, 1:    b = $urandom_range(0, TABLE_SIZE - 1);
      2, 3:    b = int'(cur_end) + int'($urandom_range(0, 5)) - 3;
      default: b = (cur_end == 0) ? 0 : int'($urandom_range(0, cur_end - 1));
    endcase
    if (b < 0) begin
      b = 0;
    end
    if (b > TABLE_SIZE - 1) begin
      b = TABLE_SIZE - 1;
    end
    return b[POS_W-1:0];
  endfunction

  task automatic send_transfer(input logic op, input logic [POS_W-1:0] pos,
                               input logic [COEF_W-1:0] val,
                               input logic [SAMPLE_W-1:0] br, input logic [SAMPLE_W-1:0] bi,
                               input logic [SAMPLE_W-1:0] mr, input logic [SAMPLE_W-1:0] mi);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    position    <= pos;
    table_value <= val;
    bin_re      <= br;
    bin_im      <= bi;
    mirror_re   <= mr;
    mirror_im   <= mi;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_entry(input logic [POS_W-1:0] pos, input logic [COEF_W-1:0] val);
    send_transfer(OP_LOAD, pos, val, $urandom, $urandom, $urandom, $urandom);
    loaded[pos] = 1'b1;
    load_count++;
  endtask

  // The table entry that a bin maps to is always loaded before the bin is sent.
  task automatic send_bin(input logic [POS_W-1:0] q,
                          input logic [SAMPLE_W-1:0] br, input logic [SAMPLE_W-1:0] bi,
                          input logic [SAMPLE_W-1:0] mr, input logic [SAMPLE_W-1:0] mi);
    logic [STEP_W+POS_W-1:0] idx;
    idx = cur_step * q;
    idx = idx >> FRAC_STEP;
    if (idx > TABLE_SIZE - 1) begin
      idx = (STEP_W+POS_W)'(TABLE_SIZE - 1);
    end
    if (!loaded[idx[ADDR_W-1:0]]) begin
      load_entry(idx[ADDR_W-1:0], random_coef());
    end
    send_transfer(OP_PROCESS, q, COEF_W'($urandom), br, bi, mr, mi);
    bin_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic configure(input logic [STEP_W-1:0] st, input logic [END_W-1:0] en,
                           input logic cj, input logic ds);
    drain();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP;
    cfg_data  <= st;
    @(posedge clk);
    cfg_index <= CFG_END_BIN;
    cfg_data  <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_index <= CFG_CONJ_MODE;
    cfg_data  <= CFG_DATA_W'(cj);
    @(posedge clk);
    cfg_index <= CFG_DOUBLE_SIDED;
    cfg_data  <= CFG_DATA_W'(ds);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_step = st;
    cur_end  = en;
    setting_count++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_entry(0, 16'h4000);
    load_entry(5, 16'hFFFF);
    load_entry(2047, 16'h0000);
    send_bin(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_bin(5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'hC000_0000);
    send_bin(5, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_bin(2047, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h8765_4321);
    send_bin(2048, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(4095, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA);

    configure(24'hFF_FFFF, 12'd2048, 1'b1, 1'b1);
    send_bin(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_bin(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_bin(5, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_C000, 32'h0000_3FFF);
    send_bin(2047, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_4000, 32'hFFFF_FFFF);

    configure('0, '0, 1'b0, 1'b1);
    send_bin(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_bin(3, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);

    configure('0, 12'd1, 1'b1, 1'b0);
    send_bin(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_bin(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 36;
          rx_idle_pct = 71;
          configure(STEP_RESET, END_BIN_RESET, 1'b0, 1'b1);
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 36;
          configure(STEP_W'($urandom_range(1, 24'h2000)), END_W'($urandom_range(1, 2048)),
                    1'b1, 1'b0);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          configure(STEP_W'($urandom_range(24'h400, 24'h1800)), 12'd2048, 1'b1, 1'b1);
        end
      endcase
      for (int n = 0; n < 330; n++) begin
        if (n == 165) begin
          drain();
        end
        if ($urandom_range(0, 99) < 15) begin
          load_entry(POS_W'($urandom_range(0, TABLE_SIZE - 1)), random_coef());
        end else begin
          send_bin(random_bin(), random_sample(), random_sample(), random_sample(),
                   random_sample());
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d table loads and %0d bin pairs across %0d register settings.",
             load_count, bin_count, setting_count);
    $display("%0d results compared, %0d field mismatches.", results, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
